/* src/toy_8bit_cpu_core_assert.svh */
// Assertion macros shared by the toy 8-bit CPU core sources.
// Bodies are empty when SYNTHESIS is defined.
`ifndef TOY_8BIT_CPU_CORE_ASSERT_SVH
`define TOY_8BIT_CPU_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define T8C_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define T8C_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define T8C_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define T8C_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

/* src/t8c_pkg.sv */
// Types and constants of the toy 8-bit CPU core.
// No dependencies.
`timescale 1ns / 1ps
package t8c_pkg;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT = 1'd1;

	localparam logic [8:0] SECTOR_SIZE_RST = 9'd256;
	localparam logic [8:0] DEVICE_COUNT_RST = 9'd255;
	localparam logic [8:0] SIZE_MAX = 9'd256;

	localparam int MOD_DVD_W = 16;
	localparam int MOD_DIV_W = 17;

	localparam logic [3:0] REG_OP0 = 4'h0;
	localparam logic [3:0] REG_OP1 = 4'h1;
	localparam logic [3:0] REG_DEV_SEL = 4'hA;
	localparam logic [3:0] REG_STK_HI = 4'hB;
	localparam logic [3:0] REG_STK_LO = 4'hC;
	localparam logic [3:0] REG_FLAGS = 4'hD;
	localparam logic [3:0] REG_SECTOR = 4'hF;

	localparam int FLAG_JUMP = 0;
	localparam int FLAG_DEV_WR = 1;
	localparam int FLAG_IMM = 2;
	localparam int FLAG_POP = 3;

	typedef enum logic [2:0] {
		KIND_LOAD = 3'd0,
		KIND_WREG = 3'd1,
		KIND_STEP = 3'd2,
		KIND_RDEV = 3'd3,
		KIND_RREG = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_ADD, OP_SUB, OP_AND, OP_NOR, OP_CEQ, OP_CGT, OP_MVA,
		OP_MVR, OP_FLG, OP_STR, OP_LDR, OP_STK, OP_JMP, OP_DEV, OP_HLT
	} opcode_t;

	typedef struct packed {
		logic en;
		logic [3:0] idx;
		logic [7:0] data;
	} t8c_rf_wr_t;

	typedef struct packed {
		logic [7:0] r0;
		logic [7:0] r1;
		logic [7:0] ra;
		logic [7:0] rb;
		logic [7:0] rc;
		logic [7:0] rd;
		logic [7:0] rf;
	} t8c_rf_taps_t;

	typedef struct packed {
		logic start;
		logic [MOD_DVD_W-1:0] dividend;
		logic [MOD_DIV_W-1:0] divisor;
	} t8c_mod_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [MOD_DVD_W-1:0] remainder;
	} t8c_mod_rsp_t;
endpackage

/* src/t8c_in_if.sv */
// Input item channel of the toy 8-bit CPU core: valid, ready, payload.
// No dependencies.
`timescale 1ns / 1ps
interface t8c_in_if;
	logic valid;
	logic ready;
	logic [2:0] kind;
	logic [15:0] address;
	logic [7:0] data;

	modport source (output valid, kind, address, data, input ready);
	modport sink (input valid, kind, address, data, output ready);
endinterface

/* src/t8c_out_if.sv */
// Result channel of the toy 8-bit CPU core: valid, ready, payload.
// No dependencies.
`timescale 1ns / 1ps
interface t8c_out_if;
	logic valid;
	logic ready;
	logic [7:0] read_data;
	logic [7:0] instruction;
	logic [15:0] instruction_pc;
	logic running;

	modport source (output valid, read_data, instruction, instruction_pc, running, input ready);
	modport sink (input valid, read_data, instruction, instruction_pc, running, output ready);
endinterface

/* src/t8c_mod_unit.sv */
// Shared bit-serial remainder unit, one dividend bit per cycle.
// Depends on t8c_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "toy_8bit_cpu_core_assert.svh"
module t8c_mod_unit import t8c_pkg::*; (
	input logic clk,
	input logic arst_n,
	input t8c_mod_req_t req,
	output t8c_mod_rsp_t rsp
);
	localparam int CNT_W = $clog2(MOD_DVD_W + 1);

	logic [MOD_DVD_W-1:0] dvd_q;
	logic [MOD_DIV_W-1:0] div_q;
	logic [MOD_DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	logic [MOD_DIV_W:0] trial;
	logic [MOD_DIV_W-1:0] rem_next;
	logic rem_lt_div;

	always_comb begin
		trial = {rem_q, dvd_q[MOD_DVD_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = MOD_DIV_W'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[MOD_DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q <= '0;
			div_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
			cnt_q <= CNT_W'(MOD_DVD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[MOD_DVD_W-2:0], 1'b0};
			rem_q <= rem_next;
			cnt_q <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rem_lt_div = rem_q < div_q;
	assign rsp.busy = cnt_q != '0;
	assign rsp.done = done_q;
	assign rsp.remainder = rem_q[MOD_DVD_W-1:0];

	`T8C_ASSERT_NXT(a_start_busy, clk, arst_n, req.start, rsp.busy, "start did not engage unit")
	`T8C_ASSERT_IMP(a_start_idle, clk, arst_n, req.start, !rsp.busy, "start while busy")
	`T8C_ASSERT_IMP(a_done_idle, clk, arst_n, rsp.done, !rsp.busy, "done while busy")
	`T8C_ASSERT_IMP(a_rem_range, clk, arst_n, rsp.done, rem_lt_div, "remainder not below divisor")
endmodule

/* src/t8c_regfile.sv */
// Sixteen 8-bit CPU registers: one write port, one indexed read, fixed taps.
// Depends on t8c_pkg.
`timescale 1ns / 1ps
module t8c_regfile import t8c_pkg::*; (
	input logic clk,
	input logic arst_n,
	input t8c_rf_wr_t wr,
	input logic [3:0] ridx,
	output logic [7:0] rdata,
	output t8c_rf_taps_t taps
);
	logic [7:0] regs_q [16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				regs_q[i] <= 8'h00;
			end
		end else if (wr.en) begin
			regs_q[wr.idx] <= wr.data;
		end
	end

	assign rdata = regs_q[ridx];
	assign taps.r0 = regs_q[REG_OP0];
	assign taps.r1 = regs_q[REG_OP1];
	assign taps.ra = regs_q[REG_DEV_SEL];
	assign taps.rb = regs_q[REG_STK_HI];
	assign taps.rc = regs_q[REG_STK_LO];
	assign taps.rd = regs_q[REG_FLAGS];
	assign taps.rf = regs_q[REG_SECTOR];
endmodule

/* src/toy_8bit_cpu_core.sv */
// Items go from dispatch, by kind, through memory, device or step states to finish, which
// registers the result once the output is free; register write/read, unused kinds and a
// halted step go straight there. A step fetches, executes, then may do a taken jump, stack,
// load/store or device access; the shared bit-serial unit takes a remainder only when the
// value is not already in range. One item at a time; the next transfer is taken after the
// result is registered. Reset clears main memory, no item taken; configuration writes taken.
`timescale 1ns / 1ps
`include "toy_8bit_cpu_core_assert.svh"
module toy_8bit_cpu_core import t8c_pkg::*; #(
	parameter int MEM_DEPTH = 65536,
	parameter int DEVICE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	t8c_in_if.sink item,
	t8c_out_if.source result
);
	localparam int AW = $clog2(MEM_DEPTH);
	localparam int DVW = (DEVICE_DEPTH > 1) ? $clog2(DEVICE_DEPTH) : 1;
	localparam logic [MOD_DIV_W-1:0] MEM_DIV = MOD_DIV_W'(MEM_DEPTH);
	localparam logic [MOD_DIV_W-1:0] DEV_DIV = MOD_DIV_W'(DEVICE_DEPTH);
	localparam logic [AW-1:0] MEM_LAST = AW'(MEM_DEPTH - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_RED, S_RED_W, S_EXEC, S_SADDR,
		S_MEMACC, S_MEMRD, S_DEV2, S_DEVACC, S_DEVRD, S_FINISH
	} state_t;

	state_t state_q, ret_q;
	logic [8:0] sector_size_q, device_count_q;
	logic [2:0] kind_q;
	logic [15:0] addr_q;
	logic [7:0] data_q;
	logic [15:0] pc_q;
	logic run_q;
	logic [7:0] ins_q, rd_q, wdata_q;
	logic [15:0] ipc_q, work_q;
	logic [MOD_DIV_W-1:0] div_q;
	logic we_q, fetch_q;
	logic [AW-1:0] clr_q;
	logic out_valid_q;
	logic [7:0] out_rd_q, out_ins_q;
	logic [15:0] out_ipc_q;
	logic out_run_q;

	logic [7:0] mem_q [MEM_DEPTH];
	logic [7:0] mem_rdata_q;
	logic [7:0] dev_q [DEVICE_DEPTH];
	logic [7:0] dev_rdata_q;

	logic [8:0] s_eff, d_eff;
	opcode_t opc;
	logic [3:0] opn;
	t8c_rf_wr_t rf_wr;
	logic [3:0] rf_ridx;
	logic [7:0] rf_rdata;
	t8c_rf_taps_t t;
	t8c_mod_req_t mod_req;
	t8c_mod_rsp_t mod_rsp;
	logic in_range;
	logic [16:0] prod;
	logic [15:0] saddr;
	logic mem_we, mem_re, dev_we, dev_re;
	logic [AW-1:0] mem_addr;
	logic [7:0] mem_wdata;

	t8c_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .wr(rf_wr), .ridx(rf_ridx), .rdata(rf_rdata), .taps(t)
	);

	t8c_mod_unit u_mod (
		.clk(clk), .arst_n(arst_n), .req(mod_req), .rsp(mod_rsp)
	);

	assign s_eff = (sector_size_q == 9'd0 || sector_size_q > SIZE_MAX) ? SIZE_MAX : sector_size_q;
	assign d_eff = (device_count_q == 9'd0 || device_count_q > SIZE_MAX) ? SIZE_MAX : device_count_q;
	assign opc = opcode_t'(ins_q[7:4]);
	assign opn = ins_q[3:0];
	assign rf_ridx = (state_q == S_DISPATCH) ? addr_q[3:0] : opn;
	assign in_range = {1'b0, work_q} < div_q;
	assign prod = {9'b0, t.rf} * {8'b0, s_eff};
	assign saddr = prod[15:0] + work_q;

	assign mod_req.start = (state_q == S_RED) && !in_range;
	assign mod_req.dividend = work_q;
	assign mod_req.divisor = div_q;

	always_comb begin
		rf_wr = '0;
		case (state_q)
			S_DISPATCH: begin
				if (kind_q == KIND_WREG) rf_wr = '{1'b1, addr_q[3:0], data_q};
			end
			S_EXEC: begin
				case (opc)
					OP_ADD: begin
						if (t.rd[FLAG_IMM]) rf_wr = '{1'b1, REG_OP0, t.r0 + {4'b0, opn}};
						else rf_wr = '{1'b1, opn, t.r0 + t.r1};
					end
					OP_SUB: begin
						if (t.rd[FLAG_IMM]) rf_wr = '{1'b1, REG_OP0, t.r0 - {4'b0, opn}};
						else rf_wr = '{1'b1, opn, t.r0 - t.r1};
					end
					OP_AND: rf_wr = '{1'b1, opn, t.r0 & t.r1};
					OP_NOR: rf_wr = '{1'b1, opn, ~(t.r0 | t.r1)};
					OP_CEQ: rf_wr = '{1'b1, opn, rf_rdata + {7'b0, t.r0 == t.r1}};
					OP_CGT: rf_wr = '{1'b1, opn,
						rf_rdata + {7'b0, $signed(t.r0) > $signed(t.r1)}};
					OP_MVA: rf_wr = '{1'b1, REG_OP0, rf_rdata};
					OP_MVR: rf_wr = '{1'b1, opn, t.r0};
					OP_FLG: rf_wr = '{1'b1, REG_FLAGS, t.rd ^ (8'b1 << opn[2:0])};
					OP_STK: begin
						if (t.rd[FLAG_POP]) rf_wr = '{1'b1, REG_STK_LO, t.rc - 8'd1};
						else rf_wr = '{1'b1, REG_STK_LO, t.rc + 8'd1};
					end
					default: rf_wr = '0;
				endcase
			end
			S_MEMRD: begin
				if (!fetch_q) rf_wr = '{1'b1, opn, mem_rdata_q};
			end
			S_DEVRD: begin
				if (kind_q == KIND_STEP) rf_wr = '{1'b1, opn, dev_rdata_q};
			end
			default: rf_wr = '0;
		endcase
	end

	assign mem_we = (state_q == S_CLEAR) || (state_q == S_MEMACC && we_q);
	assign mem_re = (state_q == S_MEMACC) && !we_q;
	assign mem_addr = (state_q == S_CLEAR) ? clr_q : work_q[AW-1:0];
	assign mem_wdata = (state_q == S_CLEAR) ? 8'h00 : wdata_q;
	assign dev_we = (state_q == S_DEVACC) && we_q;
	assign dev_re = (state_q == S_DEVACC) && !we_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_addr] <= mem_wdata;
		if (mem_re) mem_rdata_q <= mem_q[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (dev_we) dev_q[work_q[DVW-1:0]] <= wdata_q;
		if (dev_re) dev_rdata_q <= dev_q[work_q[DVW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q <= S_IDLE;
			sector_size_q <= SECTOR_SIZE_RST;
			device_count_q <= DEVICE_COUNT_RST;
			kind_q <= '0;
			addr_q <= '0;
			data_q <= '0;
			pc_q <= '0;
			run_q <= 1'b1;
			ins_q <= '0;
			rd_q <= '0;
			wdata_q <= '0;
			ipc_q <= '0;
			work_q <= '0;
			div_q <= '0;
			we_q <= 1'b0;
			fetch_q <= 1'b0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			out_rd_q <= '0;
			out_ins_q <= '0;
			out_ipc_q <= '0;
			out_run_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SECTOR_SIZE: sector_size_q <= cfg_data;
					CFG_DEVICE_COUNT: device_count_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && result.ready && state_q != S_FINISH) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_LAST) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item.valid) begin
						kind_q <= item.kind;
						addr_q <= item.address;
						data_q <= item.data;
						rd_q <= '0;
						ins_q <= '0;
						ipc_q <= '0;
						fetch_q <= 1'b0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (kind_q)
						KIND_LOAD: begin
							work_q <= addr_q;
							div_q <= MEM_DIV;
							we_q <= 1'b1;
							wdata_q <= data_q;
							ret_q <= S_MEMACC;
							state_q <= S_RED;
						end
						KIND_STEP: begin
							if (run_q) begin
								ipc_q <= pc_q;
								work_q <= pc_q;
								div_q <= MEM_DIV;
								we_q <= 1'b0;
								fetch_q <= 1'b1;
								ret_q <= S_MEMACC;
								state_q <= S_RED;
							end else begin
								state_q <= S_FINISH;
							end
						end
						KIND_RDEV: begin
							work_q <= addr_q;
							div_q <= {8'b0, d_eff};
							we_q <= 1'b0;
							ret_q <= S_DEV2;
							state_q <= S_RED;
						end
						KIND_RREG: begin
							rd_q <= rf_rdata;
							state_q <= S_FINISH;
						end
						default: state_q <= S_FINISH;
					endcase
				end
				S_RED: begin
					if (in_range) state_q <= ret_q;
					else state_q <= S_RED_W;
				end
				S_RED_W: begin
					if (mod_rsp.done) begin
						work_q <= mod_rsp.remainder;
						state_q <= ret_q;
					end
				end
				S_EXEC: begin
					wdata_q <= rf_rdata;
					case (opc)
						OP_STR, OP_LDR: begin
							work_q <= {8'b0, t.r0};
							div_q <= {8'b0, s_eff};
							we_q <= (opc == OP_STR);
							ret_q <= S_SADDR;
							state_q <= S_RED;
						end
						OP_JMP: begin
							if (t.rd[FLAG_JUMP]) begin
								work_q <= {8'b0, rf_rdata};
								div_q <= {8'b0, s_eff};
								ret_q <= S_SADDR;
								state_q <= S_RED;
							end else begin
								state_q <= S_FINISH;
							end
						end
						OP_STK: begin
							we_q <= !t.rd[FLAG_POP];
							work_q <= t.rd[FLAG_POP] ? {t.rb, t.rc - 8'd1} : {t.rb, t.rc};
							div_q <= MEM_DIV;
							ret_q <= S_MEMACC;
							state_q <= S_RED;
						end
						OP_DEV: begin
							we_q <= t.rd[FLAG_DEV_WR];
							work_q <= {8'b0, t.ra};
							div_q <= {8'b0, d_eff};
							ret_q <= S_DEV2;
							state_q <= S_RED;
						end
						OP_HLT: begin
							run_q <= 1'b0;
							state_q <= S_FINISH;
						end
						default: state_q <= S_FINISH;
					endcase
				end
				S_SADDR: begin
					if (opc == OP_JMP) begin
						pc_q <= saddr;
						state_q <= S_FINISH;
					end else begin
						work_q <= saddr;
						div_q <= MEM_DIV;
						ret_q <= S_MEMACC;
						state_q <= S_RED;
					end
				end
				S_MEMACC: begin
					if (we_q) state_q <= S_FINISH;
					else state_q <= S_MEMRD;
				end
				S_MEMRD: begin
					if (fetch_q) begin
						ins_q <= mem_rdata_q;
						pc_q <= pc_q + 16'd1;
						fetch_q <= 1'b0;
						state_q <= S_EXEC;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_DEV2: begin
					div_q <= DEV_DIV;
					ret_q <= S_DEVACC;
					state_q <= S_RED;
				end
				S_DEVACC: begin
					if (we_q) state_q <= S_FINISH;
					else state_q <= S_DEVRD;
				end
				S_DEVRD: begin
					if (kind_q == KIND_RDEV) rd_q <= dev_rdata_q;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_rd_q <= rd_q;
						out_ins_q <= ins_q;
						out_ipc_q <= ipc_q;
						out_run_q <= run_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.read_data = out_rd_q;
	assign result.instruction = out_ins_q;
	assign result.instruction_pc = out_ipc_q;
	assign result.running = out_run_q;

	`T8C_ASSERT_IMP(a_ready_unit_idle, clk, arst_n, item.ready, !mod_rsp.busy, "ready while unit busy")
	`T8C_ASSERT_NXT(a_one_item, clk, arst_n, item.valid && item.ready, !item.ready, "second transfer")
	`T8C_ASSERT_NXT(a_halt_sticky, clk, arst_n, !run_q, !run_q, "halt released")
	`T8C_ASSERT_IMP(a_mod_consumed, clk, arst_n, mod_rsp.done, state_q == S_RED_W, "remainder unused")
endmodule
